// ===== hw/rtl/tebs_pkg.sv =====
`timescale 1ns / 1ps

package tebs_pkg;

    localparam int CLIENTS     = 64;
    localparam int CLIENT_W    = $clog2(CLIENTS);
    localparam int RATE_LEVELS = 4;
    localparam int RATE_W      = 16;
    localparam int KBPS_W      = 32;
    localparam int BYTES_W     = 24;
    localparam int DUR_W       = 32;
    localparam int ALPHA_W     = 9;
    localparam int COUNT_W     = 3;

    // bytes * 8000 needs 24 + 13 bits
    localparam int KBPS_SCALE  = 8000;
    localparam int DIVIDEND_W  = BYTES_W + $clog2(KBPS_SCALE);
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(128);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_COUNT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LEVEL_0 = CFG_IDX_W'(2);
    localparam int CFG_DATA_W = 16;

    localparam logic MODE_FRAG = 1'b0;
    localparam logic MODE_PICK = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [CLIENT_W-1:0] client;
        logic [BYTES_W-1:0] frag_bytes;
        logic [DUR_W-1:0]   duration_us;
    } t_req;

    typedef struct packed {
        logic [KBPS_W-1:0] inst_kbps;
        logic [KBPS_W-1:0] avg_kbps;
        logic [RATE_W-1:0] chosen_rate;
    } t_res;

    function automatic logic [RATE_W-1:0] rate_reset(input int k);
        logic [RATE_W-1:0] v;
        case (k)
            0:       v = RATE_W'(10);
            1:       v = RATE_W'(100);
            2:       v = RATE_W'(500);
            3:       v = RATE_W'(1000);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/tebs_ram.sv =====
`timescale 1ns / 1ps

module tebs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/tebs_div.sv =====
`timescale 1ns / 1ps

module tebs_div
    import tebs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DUR_W-1:0]      i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    logic                  r_run;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DUR_W-1:0]      r_div;
    logic [DUR_W-1:0]      r_rem;
    // dividend bits shift out at the top while quotient bits enter at the bottom
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DUR_W:0]   rem_sh;
    logic             ge;
    logic [DUR_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_rem <= '0;
                r_div <= i_divisor;
                r_quo <= i_dividend;
            end else if (r_run) begin
                r_rem <= ge ? rem_sub[DUR_W-1:0] : rem_sh[DUR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_run))
        else $error("divider finished without running");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_run)
        else $error("divider restarted while busy");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run && !i_start |-> r_rem < r_div)
        else $error("partial remainder not below divisor");

endmodule

// ===== hw/rtl/throughput_ewma_bitrate_selector.sv =====
`timescale 1ns / 1ps

// channel   | handshake                    | payload
// request   | start, busy                  | i_req   (t_req)
// result    | o_res_valid strobe           | o_res   (t_res)
// config    | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// a bitrate request passes S_READ and S_OLD, a fragment request also S_DIV,
// S_BLEND and S_WRITE: the restoring divider takes one quotient bit a cycle over
// the 37-bit dividend bytes*8000. one request at a time; busy falls with the strobe.
// synchronous active-low reset clears the averages through per-client valid bits.
// the result strobe lasts one cycle and cannot be held off.

module throughput_ewma_bitrate_selector
    import tebs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,
    output logic                  o_res_valid,
    output t_res                  o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_OLD,
        S_DIV,
        S_BLEND,
        S_WRITE
    } t_state;

    t_state                r_state;
    logic                  r_res_valid;
    t_res                  r_res;
    logic                  r_mode;
    logic [CLIENT_W-1:0]   r_client;
    logic [DUR_W-1:0]      r_dur;
    logic [DIVIDEND_W-1:0] r_dividend;
    logic [KBPS_W-1:0]     r_old;
    logic [KBPS_W-1:0]     r_inst;
    logic signed [42:0]    r_prod;
    logic [CLIENTS-1:0]    r_seen;
    logic                  r_div_start;

    logic [ALPHA_W-1:0]    r_alpha;
    logic [COUNT_W-1:0]    r_count;
    logic [RATE_W-1:0]     r_rate [RATE_LEVELS];

    logic                  accept;
    logic [KBPS_W-1:0]     ram_rd_data;
    logic [KBPS_W-1:0]     old_avg;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [DUR_W-1:0]      divisor;
    logic [KBPS_W-1:0]     inst_sat;
    logic [ALPHA_W-1:0]    alpha_eff;
    logic signed [KBPS_W:0] diff;
    logic signed [42:0]    prod;
    logic [KBPS_W-1:0]     new_avg;
    logic [COUNT_W:0]      count_eff;
    logic [RATE_W-1:0]     pick;
    logic                  cfg_wr;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    tebs_ram #(
        .WIDTH (KBPS_W),
        .DEPTH (CLIENTS)
    ) u_avg_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_WRITE),
        .i_wr_addr (r_client),
        .i_wr_data (new_avg),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_client),
        .o_rd_data (ram_rd_data)
    );

    // zero duration counts as one microsecond
    assign divisor = (r_dur == '0) ? DUR_W'(1) : r_dur;

    tebs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        old_avg   = r_seen[r_client] ? ram_rd_data : '0;
        inst_sat  = (div_quo[DIVIDEND_W-1:KBPS_W] != '0) ? '1 : div_quo[KBPS_W-1:0];
        alpha_eff = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
        // (a*new + (256-a)*old) >> 8 == old + floor(a*(new-old) / 256)
        diff      = $signed({1'b0, r_inst}) - $signed({1'b0, r_old});
        prod      = diff * $signed({1'b0, alpha_eff});
        new_avg   = r_old + KBPS_W'(r_prod >>> 8);

        if (r_count == '0) begin
            count_eff = (COUNT_W + 1)'(1);
        end else if (int'(r_count) > RATE_LEVELS) begin
            count_eff = (COUNT_W + 1)'(RATE_LEVELS);
        end else begin
            count_eff = {1'b0, r_count};
        end

        // highest enabled level with 2*avg > 3*rate, level 0 otherwise
        pick = r_rate[0];
        for (int i = 0; i < RATE_LEVELS; i++) begin
            if (i < int'(count_eff) &&
                ({old_avg, 1'b0} > ((KBPS_W + 1)'({r_rate[i], 1'b0}) +
                                    (KBPS_W + 1)'(r_rate[i])))) begin
                pick = r_rate[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_count <= COUNT_RESET;
            for (int i = 0; i < RATE_LEVELS; i++) begin
                r_rate[i] <= rate_reset(i);
            end
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_ALPHA) begin
                r_alpha <= i_cfg_data[ALPHA_W-1:0];
            end
            if (i_cfg_index == CFG_RATE_COUNT) begin
                r_count <= i_cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < RATE_LEVELS; i++) begin
                if (int'(i_cfg_index) == int'(CFG_RATE_LEVEL_0) + i) begin
                    r_rate[i] <= i_cfg_data[RATE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_seen      <= '0;
        end else begin
            r_res_valid <= 1'b0;
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode     <= i_req.mode;
                        r_client   <= i_req.client;
                        r_dur      <= i_req.duration_us;
                        // bytes * 8000 as bytes * (8192 - 128 - 64)
                        r_dividend <= (DIVIDEND_W'(i_req.frag_bytes) << 13) -
                                      (DIVIDEND_W'(i_req.frag_bytes) << 7) -
                                      (DIVIDEND_W'(i_req.frag_bytes) << 6);
                        r_state    <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_OLD;
                end
                S_OLD: begin
                    r_old <= old_avg;
                    if (r_mode == MODE_PICK) begin
                        r_res.inst_kbps   <= '0;
                        r_res.avg_kbps    <= old_avg;
                        r_res.chosen_rate <= pick;
                        r_res_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_inst  <= inst_sat;
                        r_state <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    r_prod  <= prod;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_seen[r_client]  <= 1'b1;
                    r_res.inst_kbps   <= r_inst;
                    r_res.avg_kbps    <= new_avg;
                    r_res.chosen_rate <= '0;
                    r_res_valid       <= 1'b1;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request accepted but block not busy");

    a_result_ends_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy) && !busy)
        else $error("result strobe without a request in flight");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the wait state");

    a_one_kind_of_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.inst_kbps == '0) || (o_res.chosen_rate == '0))
        else $error("result carries both a throughput and a bitrate");

endmodule

// ===== test/tebs_result_checker.sv =====
`timescale 1ns / 1ps

module tebs_result_checker
    import tebs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_req                  i_req,
    input  logic                  i_res_valid,
    input  t_res                  i_res,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_outstanding
);

    localparam logic [RATE_W-1:0] LEVEL_DEFAULT [4] = '{16'd10, 16'd100, 16'd500, 16'd1000};

    logic [KBPS_W-1:0]  client_avg [CLIENTS];
    logic [ALPHA_W-1:0] alpha_q;
    logic [COUNT_W-1:0] level_count_q;
    logic [RATE_W-1:0]  level_q [RATE_LEVELS];

    t_res              due_results [$];
    t_res              want;
    logic [KBPS_W-1:0] avg_now;
    int                mismatches = 0;
    int                err_q = 0;
    int                due_q = 0;

    assign o_errors      = err_q;
    assign o_outstanding = due_q;

    function automatic logic [KBPS_W-1:0] fragment_kbps(input logic [BYTES_W-1:0] nbytes,
                                                        input logic [DUR_W-1:0] dur);
        logic [63:0] bits_milli;
        logic [63:0] divisor;
        logic [63:0] quot;
        bits_milli = 64'(nbytes);
        bits_milli = bits_milli * 64'd8000;
        divisor    = (dur == '0) ? 64'd1 : {32'd0, dur};
        quot       = bits_milli / divisor;
        return (quot > 64'hFFFF_FFFF) ? '1 : quot[KBPS_W-1:0];
    endfunction

    function automatic logic [KBPS_W-1:0] smoothed_kbps(input logic [KBPS_W-1:0] fresh,
                                                        input logic [KBPS_W-1:0] old);
        logic [63:0] weight;
        logic [63:0] f;
        logic [63:0] o;
        logic [63:0] acc;
        weight = 64'((alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q);
        f      = 64'(fresh);
        o      = 64'(old);
        acc    = weight * f + (64'd256 - weight) * o;
        return acc[KBPS_W+7:8];
    endfunction

    function automatic logic [RATE_W-1:0] chosen_level(input logic [KBPS_W-1:0] avg);
        int                n;
        logic [RATE_W-1:0] pick;
        logic              hit;
        logic [63:0]       twice_avg;
        logic [63:0]       thrice_rate;
        n = int'(level_count_q);
        if (n < 1) n = 1;
        if (n > RATE_LEVELS) n = RATE_LEVELS;
        pick      = level_q[0];
        hit       = 1'b0;
        twice_avg = {31'd0, avg, 1'b0};
        // highest entry whose 1.5x lies strictly below the average
        for (int i = n - 1; i >= 0; i--) begin
            thrice_rate = 64'(level_q[i]);
            thrice_rate = thrice_rate * 64'd3;
            if (!hit && twice_avg > thrice_rate) begin
                pick = level_q[i];
                hit  = 1'b1;
            end
        end
        return pick;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLIENTS; c++) client_avg[c] = '0;
            alpha_q       = ALPHA_RESET;
            level_count_q = COUNT_RESET;
            for (int k = 0; k < RATE_LEVELS; k++) level_q[k] = (k < 4) ? LEVEL_DEFAULT[k] : '0;
            due_results.delete();
        end else begin
            if (i_res_valid === 1'b1) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual inst %0d avg %0d rate %0d",
                             $time, i_res.inst_kbps, i_res.avg_kbps, i_res.chosen_rate);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (i_res.inst_kbps !== want.inst_kbps) begin
                        $display("%0t: inst_kbps mismatch, expected %0d actual %0d",
                                 $time, want.inst_kbps, i_res.inst_kbps);
                        mismatches++;
                    end
                    if (i_res.avg_kbps !== want.avg_kbps) begin
                        $display("%0t: avg_kbps mismatch, expected %0d actual %0d",
                                 $time, want.avg_kbps, i_res.avg_kbps);
                        mismatches++;
                    end
                    if (i_res.chosen_rate !== want.chosen_rate) begin
                        $display("%0t: chosen_rate mismatch, expected %0d actual %0d",
                                 $time, want.chosen_rate, i_res.chosen_rate);
                        mismatches++;
                    end
                end
            end

            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                if (i_cfg_index == CFG_ALPHA) begin
                    alpha_q = i_cfg_data[ALPHA_W-1:0];
                end else if (i_cfg_index == CFG_RATE_COUNT) begin
                    level_count_q = i_cfg_data[COUNT_W-1:0];
                end else if (int'(i_cfg_index) >= int'(CFG_RATE_LEVEL_0) &&
                             int'(i_cfg_index) < int'(CFG_RATE_LEVEL_0) + RATE_LEVELS) begin
                    level_q[int'(i_cfg_index) - int'(CFG_RATE_LEVEL_0)] = i_cfg_data[RATE_W-1:0];
                end
            end

            if (i_start === 1'b1 && i_busy === 1'b0) begin
                // clients beyond the table read as zero and are never written
                avg_now = (int'(i_req.client) < CLIENTS) ? client_avg[i_req.client] : '0;
                if (i_req.mode == MODE_FRAG) begin
                    want.inst_kbps = fragment_kbps(i_req.frag_bytes, i_req.duration_us);
                    if (int'(i_req.client) < CLIENTS) begin
                        avg_now = smoothed_kbps(want.inst_kbps, avg_now);
                        client_avg[i_req.client] = avg_now;
                    end
                    want.chosen_rate = '0;
                end else begin
                    want.inst_kbps   = '0;
                    want.chosen_rate = chosen_level(avg_now);
                end
                want.avg_kbps = avg_now;
                due_results.push_back(want);
            end
        end
        err_q <= mismatches;
        due_q <= due_results.size();
    end

endmodule

// ===== test/tb_throughput_ewma_bitrate_selector.sv =====
`timescale 1ns / 1ps

module tb_throughput_ewma_bitrate_selector
    import tebs_pkg::*;
();

    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(CFG_RATE_LEVEL_0 + RATE_LEVELS);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  req = '0;
    logic                  res_valid;
    t_res                  res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int errors;
    int outstanding;
    int quiet_cycles = 0;
    int idle_pct = 0;
    int n_frag = 0;
    int n_pick = 0;
    int n_writes = 0;
    int n_settings = 0;

    t_req              item;
    int                hot;
    int                level;
    logic [RATE_W-1:0] step_mask;
    logic              ascending;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    throughput_ewma_bitrate_selector dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tebs_result_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (req),
        .i_res_valid   (res_valid),
        .i_res         (res),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        if ((start === 1'b1 && busy === 1'b0) || res_valid === 1'b1 ||
            (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue(input t_req r);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            // sometimes let the gap start once the block has gone idle
            if ($urandom_range(1) == 1) begin
                @(posedge clk);
                while (busy !== 1'b0) @(posedge clk);
            end
            repeat ($urandom_range(9, 1)) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy !== 1'b0);
        if (r.mode == MODE_FRAG) n_frag++;
        else n_pick++;
    endtask

    task automatic frag(input int c, input logic [BYTES_W-1:0] nbytes, input logic [DUR_W-1:0] dur);
        t_req r;
        r.mode        = MODE_FRAG;
        r.client      = CLIENT_W'(c);
        r.frag_bytes  = nbytes;
        r.duration_us = dur;
        issue(r);
    endtask

    task automatic pick(input int c);
        t_req r;
        r.mode        = MODE_PICK;
        r.client      = CLIENT_W'(c);
        r.frag_bytes  = BYTES_W'($urandom);
        r.duration_us = $urandom;
        issue(r);
    endtask

    // wait until every request has produced its result
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        n_writes++;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset values first, then saturation and zero duration
        idle_pct = 20;
        pick(0);
        frag(0, 24'd0, 32'd0);
        frag(1, 24'hFFFFFF, 32'd0);
        frag(1, 24'hFFFFFF, 32'd1);
        frag(2, 24'hFFFFFF, 32'hFFFF_FFFF);
        frag(63, 24'd1000, 32'd1000);
        pick(63);
        pick(1);

        // strict compare at exactly 1.5x, full-weight samples
        write_reg(CFG_ALPHA, 16'd256);
        write_reg(CFG_RATE_COUNT, 16'd4);
        write_reg(CFG_RATE_LEVEL_0, 16'd1);
        write_reg(CFG_IDX_W'(CFG_RATE_LEVEL_0 + 1), 16'd10);
        write_reg(CFG_IDX_W'(CFG_RATE_LEVEL_0 + 2), 16'd1000);
        write_reg(CFG_IDX_W'(CFG_RATE_LEVEL_0 + 3), 16'hFFFF);
        n_settings++;
        frag(5, 24'd15, 32'd8000);
        pick(5);
        frag(5, 24'd16, 32'd8000);
        pick(5);
        frag(6, 24'hFFFFFF, 32'd0);
        pick(6);

        // zero weight keeps the old average
        write_reg(CFG_ALPHA, 16'd0);
        n_settings++;
        frag(5, 24'hFFFFFF, 32'd1);
        pick(5);

        // alpha above one and count above the table both saturate
        write_reg(CFG_ALPHA, 16'h01FF);
        write_reg(CFG_RATE_COUNT, 16'd7);
        n_settings++;
        frag(7, 24'd3000, 32'd1);
        pick(7);

        // count zero, writes to spare indexes, lowest level at both extremes
        write_reg(CFG_RATE_COUNT, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        write_reg(CFG_IDX_W'(CFG_SPARE + 1), 16'hFFFF);
        n_settings++;
        pick(7);
        write_reg(CFG_RATE_LEVEL_0, 16'd0);
        n_settings++;
        pick(0);
        frag(8, 24'd1, 32'd8001);
        write_reg(CFG_RATE_LEVEL_0, 16'hFFFF);
        write_reg(CFG_ALPHA, 16'd1);
        n_settings++;
        pick(7);
        pick(0);
        frag(7, 24'd1, 32'd1);

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(5))
                0:       write_reg(CFG_ALPHA, 16'd0);
                1:       write_reg(CFG_ALPHA, 16'd256);
                2:       write_reg(CFG_ALPHA, 16'h01FF);
                3:       write_reg(CFG_ALPHA, 16'd1);
                default: write_reg(CFG_ALPHA, CFG_DATA_W'($urandom_range(511)));
            endcase
            write_reg(CFG_RATE_COUNT, CFG_DATA_W'($urandom_range(7)));
            ascending = $urandom_range(3) != 0;
            step_mask = 16'hFFFF >> $urandom_range(15, 1);
            level = 0;
            for (int k = 0; k < RATE_LEVELS; k++) begin
                if (ascending) begin
                    level = level + int'($urandom & step_mask);
                    if (level > 65535) level = 65535;
                end else begin
                    level = $urandom_range(65535);
                end
                write_reg(CFG_IDX_W'(int'(CFG_RATE_LEVEL_0) + k), CFG_DATA_W'(level));
            end
            if ($urandom_range(3) == 0)
                write_reg(CFG_IDX_W'(CFG_SPARE + $urandom_range(1)), CFG_DATA_W'($urandom));
            n_settings++;

            case ($urandom_range(3))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                2:       idle_pct = 25;
                default: idle_pct = 50;
            endcase
            if (ph == PHASES - 1) idle_pct = 0;
            hot = $urandom_range(CLIENTS - 1);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph != PHASES - 1 && $urandom_range(99) == 0) drain();
                item.mode = 1'($urandom_range(1));
                // most traffic on a few clients so their averages build up
                if ($urandom_range(9) < 6) item.client = CLIENT_W'(hot + $urandom_range(3));
                else item.client = CLIENT_W'($urandom);
                item.frag_bytes = BYTES_W'($urandom >> $urandom_range(BYTES_W - 1));
                case ($urandom_range(9))
                    0:       item.duration_us = '0;
                    1:       item.duration_us = '1;
                    default: item.duration_us = $urandom >> $urandom_range(31);
                endcase
                issue(item);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d fragment updates and %0d bitrate requests", n_frag, n_pick);
        $display("over %0d register settings (%0d writes) with sender gaps and drain pauses",
                 n_settings, n_writes);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tebs_pkg.sv
hw/rtl/tebs_ram.sv
hw/rtl/tebs_div.sv
hw/rtl/throughput_ewma_bitrate_selector.sv
test/tebs_result_checker.sv
test/tb_throughput_ewma_bitrate_selector.sv
